// ===== rtl/running_mean_variance_top_assert.svh =====
// Assertion macros for the running mean and variance block.
`ifndef RUNNING_MEAN_VARIANCE_TOP_ASSERT_SVH
`define RUNNING_MEAN_VARIANCE_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
`define RMV_ASSERT_IMP(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("running_mean_variance check failed");
`define RMV_ASSERT_NXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("running_mean_variance check failed");
`else
`define RMV_ASSERT_IMP(name, clk, rst, ante, cons)
`define RMV_ASSERT_NXT(name, clk, rst, ante, cons)
`endif

`endif

// ===== rtl/rmv_pkg.sv =====
// Package with the types and constants of the running mean and variance block.
package rmv_pkg;

  localparam int VALUE_W = 32;
  localparam int HALF_W  = 17;
  localparam int OPND_W  = 2 * HALF_W;
  localparam int ACC_W   = 2 * OPND_W;
  localparam int DCNT_W  = 6;

  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV1,
    ST_MEAN,
    ST_ERR,
    ST_MUL,
    ST_SAT,
    ST_DIV2,
    ST_DONE
  } st_t;

endpackage

// ===== rtl/running_mean_variance_top.sv =====
// Running per-variable mean and variance, Welford recurrence in Q15.16.
//
// The input stream carries one word per item: s_tuser[0] is the operation
// (add one element or clear the sample count), s_tuser[3:1] the variable,
// s_tdata the signed Q15.16 value and s_tlast marks the end of a sample.
// Every input word gives one output word: updated mean, updated variance and
// the sample count after the item.
// An element's result is built after acceptance from one read of the
// mean and variance memories, a 33-step bit-serial divider for the mean, a
// shared 17x17 multiplier for the two products, and the same divider for 32
// steps of the variance quotient. A saturated variance skips that division.
// Clear commands and elements of a variable at or above NUM_VARS skip all
// work and go straight from the idle state to the done state.
// One item is in work at a time; s_tready is high only while the block waits
// for an item, from the cycle after each result is loaded, so a new item is
// taken only once the last one is through. The result sits in an output
// register, so a new item is taken while the receiver stalls; a finished
// result waits until that register is free.
// Reset clears the sample count and the handshakes. The memories keep their
// contents; after a clear the next sample overwrites each variable that it carries.
`include "running_mean_variance_top_assert.svh"

module running_mean_variance_top #(
  parameter int NUM_VARS   = 8,
  parameter int COUNT_BITS = 24
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       s_tvalid,
  output logic                                       s_tready,
  // value (signed Q15.16) in bits 31:0
  input  logic [rmv_pkg::VALUE_W-1:0]                s_tdata,
  // op in bit 0, var_index in bits 3:1
  input  logic [3:0]                                 s_tuser,
  input  logic                                       s_tlast,
  output logic                                       m_tvalid,
  input  logic                                       m_tready,
  // mean_out in bits 31:0, variance_out in bits 63:32,
  // sample_count above it, zero filled to whole bytes
  output logic [((64+COUNT_BITS+7)/8)*8-1:0]         m_tdata
);
  import rmv_pkg::*;

  localparam int IDX_W  = (NUM_VARS > 1) ? $clog2(NUM_VARS) : 1;
  localparam int NW     = COUNT_BITS + 1;
  localparam int TD_W   = ((64 + COUNT_BITS + 7) / 8) * 8;
  localparam int PAD_W  = TD_W - 64 - COUNT_BITS;

  st_t state, state_next;

  logic [VALUE_W-1:0]    means [NUM_VARS];
  logic [VALUE_W-1:0]    variances [NUM_VARS];
  logic [VALUE_W-1:0]    rd_mean;
  logic [VALUE_W-1:0]    rd_var;
  logic [VALUE_W-1:0]    mean_old;
  logic [VALUE_W-1:0]    var_old;

  logic [VALUE_W-1:0]    x_r;
  logic [IDX_W-1:0]      idx_r;
  logic                  last_r;
  logic                  clear_r;
  logic                  elem_r;
  logic [NW-1:0]         n_r;
  logic                  neg_r;
  logic [VALUE_W:0]      dmag;
  logic [VALUE_W:0]      emag;
  logic [VALUE_W-1:0]    mean_upd;
  logic [VALUE_W:0]      dq;
  logic [NW-1:0]         rem;
  logic [DCNT_W-1:0]     dcnt;
  logic [3:0]            k;
  logic [OPND_W-1:0]     pp;
  logic [1:0]            pp_sh;
  logic [ACC_W-1:0]      acc;
  logic                  sat_r;
  logic [COUNT_BITS-1:0] count;
  logic [VALUE_W-1:0]    out_mean;
  logic [VALUE_W-1:0]    out_var;
  logic [COUNT_BITS-1:0] out_cnt;

  logic                  accept;
  logic                  fire;
  logic                  in_range;
  logic [IDX_W+2:0]      idx_ext;
  logic [IDX_W-1:0]      rd_addr;
  logic [NW:0]           trial;
  logic                  ge;
  logic [NW-1:0]         rem_step;
  logic [VALUE_W+1:0]    diff;
  logic [VALUE_W+1:0]    q_s;
  logic [VALUE_W+1:0]    mean_sum;
  logic [VALUE_W+1:0]    err;
  logic [OPND_W-1:0]     opnd_a;
  logic [OPND_W-1:0]     opnd_b;
  logic [HALF_W-1:0]     half_a;
  logic [HALF_W-1:0]     half_b;
  logic [ACC_W-1:0]      pp_shifted;
  logic [ACC_W-1:0]      acc_base;
  logic                  var_sat;

  assign accept   = s_tvalid && s_tready;
  assign fire     = (state == ST_DONE) && (!m_tvalid || m_tready);
  assign idx_ext  = {{IDX_W{1'b0}}, s_tuser[3:1]};
  assign rd_addr  = idx_ext[IDX_W-1:0];
  assign in_range = {29'd0, s_tuser[3:1]} < 32'(NUM_VARS);

  // With a zero count the stored entry plays no part, and it may never have been written.
  assign mean_old = (n_r == NW'(1)) ? '0 : rd_mean;
  assign var_old  = (n_r == NW'(1)) ? '0 : rd_var;

  // One restoring divider step, shared by the mean and the variance quotient.
  assign trial    = {rem, dq[VALUE_W]};
  assign ge       = trial >= {1'b0, n_r};
  assign rem_step = ge ? NW'(trial - {1'b0, n_r}) : trial[NW-1:0];

  assign diff     = {{2{x_r[VALUE_W-1]}}, x_r} - {{2{mean_old[VALUE_W-1]}}, mean_old};
  assign q_s      = neg_r ? ((VALUE_W+2)'(0) - {1'b0, dq}) : {1'b0, dq};
  assign mean_sum = {{2{mean_old[VALUE_W-1]}}, mean_old} + q_s;
  assign err      = {{2{x_r[VALUE_W-1]}}, x_r} - {{2{mean_upd[VALUE_W-1]}}, mean_upd};

  // First four products build d*e, the next four count*var.
  assign opnd_a = k[2] ? OPND_W'(count) : {1'b0, dmag};
  assign opnd_b = k[2] ? OPND_W'(var_old) : {1'b0, emag};
  assign half_a = k[1] ? opnd_a[OPND_W-1:HALF_W] : opnd_a[HALF_W-1:0];
  assign half_b = k[0] ? opnd_b[OPND_W-1:HALF_W] : opnd_b[HALF_W-1:0];

  always_comb begin
    case (pp_sh)
      2'd0:    pp_shifted = ACC_W'(pp);
      2'd1:    pp_shifted = ACC_W'(pp) << HALF_W;
      2'd2:    pp_shifted = ACC_W'(pp) << HALF_W;
      default: pp_shifted = ACC_W'(pp) << OPND_W;
    endcase
  end

  // Once d*e is complete it is scaled down to t before count*var is added.
  assign acc_base = (k == 4'd5) ? (acc >> 16) : acc;
  assign var_sat  = acc[ACC_W-1:32] >= (ACC_W-32)'(n_r);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          if (s_tuser[0] == OP_CLEAR || !in_range) begin
            state_next = ST_DONE;
          end else begin
            state_next = ST_LOAD;
          end
        end
      end
      ST_LOAD: state_next = ST_DIV1;
      ST_DIV1: begin
        if (dcnt == '0) begin
          state_next = ST_MEAN;
        end
      end
      ST_MEAN: state_next = ST_ERR;
      ST_ERR:  state_next = ST_MUL;
      ST_MUL: begin
        if (k == 4'd8) begin
          state_next = ST_SAT;
        end
      end
      ST_SAT: begin
        if (var_sat) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_DIV2;
        end
      end
      ST_DIV2: begin
        if (dcnt == '0) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Statistics memories: one read at acceptance, one write when an element's result is loaded into the output register.
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_mean <= means[rd_addr];
      rd_var  <= variances[rd_addr];
    end
    if (fire && elem_r) begin
      means[idx_r]     <= mean_upd;
      variances[idx_r] <= sat_r ? '1 : dq[VALUE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        x_r     <= s_tdata;
        idx_r   <= rd_addr;
        last_r  <= s_tlast;
        clear_r <= (s_tuser[0] == OP_CLEAR);
        elem_r  <= (s_tuser[0] == OP_ADD) && in_range;
        n_r     <= NW'(count) + NW'(1);
        sat_r   <= 1'b0;
      end
      ST_LOAD: begin
        neg_r <= diff[VALUE_W+1];
        dmag  <= diff[VALUE_W+1] ? (VALUE_W+1)'(0) - diff[VALUE_W:0] : diff[VALUE_W:0];
        dq    <= diff[VALUE_W+1] ? (VALUE_W+1)'(0) - diff[VALUE_W:0] : diff[VALUE_W:0];
        rem   <= '0;
        dcnt  <= DCNT_W'(VALUE_W);
      end
      ST_DIV1, ST_DIV2: begin
        rem  <= rem_step;
        dq   <= {dq[VALUE_W-1:0], ge};
        dcnt <= dcnt - DCNT_W'(1);
      end
      ST_MEAN: begin
        mean_upd <= mean_sum[VALUE_W-1:0];
      end
      ST_ERR: begin
        emag <= err[VALUE_W+1] ? (VALUE_W+1)'(0) - err[VALUE_W:0] : err[VALUE_W:0];
        acc  <= '0;
        k    <= '0;
      end
      ST_MUL: begin
        pp    <= half_a * half_b;
        pp_sh <= k[1:0];
        if (k != 4'd0) begin
          acc <= acc_base + pp_shifted;
        end
        k <= k + 4'd1;
      end
      ST_SAT: begin
        sat_r <= var_sat;
        rem   <= acc[32+NW-1:32];
        dq    <= {acc[31:0], 1'b0};
        dcnt  <= DCNT_W'(VALUE_W - 1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (fire) begin
        m_tvalid <= 1'b1;
        if (clear_r) begin
          count <= '0;
        end else if (last_r && count != '1) begin
          count <= count + COUNT_BITS'(1);
        end
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_mean <= elem_r ? mean_upd : '0;
      out_var  <= !elem_r ? '0 : (sat_r ? '1 : dq[VALUE_W-1:0]);
      if (clear_r) begin
        out_cnt <= '0;
      end else if (last_r && count != '1) begin
        out_cnt <= count + COUNT_BITS'(1);
      end else begin
        out_cnt <= count;
      end
    end
  end

  generate
    if (PAD_W > 0) begin : g_pad
      assign m_tdata = {{PAD_W{1'b0}}, out_cnt, out_var, out_mean};
    end else begin : g_nopad
      assign m_tdata = {out_cnt, out_var, out_mean};
    end
  endgenerate

  `RMV_ASSERT_NXT(a_one_in_flight, clk, rst, accept, !s_tready)
  `RMV_ASSERT_IMP(a_rem_below_n, clk, rst, (state == ST_DIV1 || state == ST_DIV2), rem < n_r)
  `RMV_ASSERT_NXT(a_count_held, clk, rst, !fire, $stable(count))
  `RMV_ASSERT_IMP(a_result_from_done, clk, rst, $rose(m_tvalid), $past(state) == ST_DONE)

endmodule

// ===== tb/sv/tb_running_mean_variance_top.sv =====
// Testbench for the running mean and variance block: predicted results checked word by word.
`timescale 1ns / 1ps

module tb_running_mean_variance_top;
  import rmv_pkg::*;

  localparam int NUM_VARS    = 8;
  localparam int COUNT_W     = 24;
  localparam int M_W         = ((64 + COUNT_W + 7) / 8) * 8;
  localparam longint unsigned COUNT_MAX = (64'd1 << COUNT_W) - 1;
  localparam int PER_PHASE   = 500;
  localparam int HOLD_CYCLES = 400;
  localparam int IDLE_LIMIT  = 5000;
  localparam int END_CYCLES  = 200;

  typedef struct packed {
    logic        op;
    logic [2:0]  idx;
    logic [31:0] value;
    logic        last;
  } stat_word_t;

  typedef struct packed {
    logic [31:0]        mean;
    logic [31:0]        variance;
    logic [COUNT_W-1:0] count;
  } stat_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [31:0]        s_tdata = '0;
  logic [3:0]         s_tuser = '0;
  logic               s_tlast = 1'b0;
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [M_W-1:0]     m_tdata;

  stat_word_t   pending_words[$];
  stat_result_t expected_results[$];

  // Predicted state of the block.
  longint          run_mean[NUM_VARS];
  longint unsigned run_var[NUM_VARS];
  longint unsigned run_count = 0;

  // Shadow of the stimulus so that no never-written entry is read while count > 0.
  bit gen_written[NUM_VARS];
  bit gen_counting = 1'b0;

  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  int  hold_req = 0;
  int  hold_taken = 0;
  int  hold_left = 0;
  int  mismatch_count = 0;
  logic word_taken = 1'b0;

  running_mean_variance_top #(
    .NUM_VARS(NUM_VARS),
    .COUNT_BITS(COUNT_W)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .s_tlast(s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  always #5 clk = ~clk;

  function automatic stat_result_t welford_update(input stat_word_t w);
    stat_result_t    r;
    longint          n, x, old_m, d, q, new_m, e;
    longint unsigned nu, md, me, t, a, vq;
    r = '0;
    if (w.op == OP_CLEAR) begin
      run_count = 0;
    end else begin
      nu = run_count + 1;
      n = nu;
      x = longint'($signed(w.value));
      old_m = run_mean[w.idx];
      d = x - old_m;
      q = d / n;
      new_m = old_m + q;
      e = x - new_m;
      md = (d < 0) ? -d : d;
      me = (e < 0) ? -e : e;
      t = (md * me) >> 16;
      a = (nu - 1) * run_var[w.idx];
      // Split quotient keeps the sum of the two terms from overflowing.
      vq = a / nu + t / nu + (a % nu + t % nu) / nu;
      if (vq > 64'hFFFF_FFFF) vq = 64'hFFFF_FFFF;
      run_mean[w.idx] = new_m;
      run_var[w.idx] = vq;
      r.mean = new_m[31:0];
      r.variance = vq[31:0];
      if (w.last && run_count < COUNT_MAX) run_count++;
    end
    r.count = run_count[COUNT_W-1:0];
    return r;
  endfunction

  task automatic queue_word(input logic op, input logic [2:0] idx, input logic [31:0] value,
                            input logic last);
    stat_word_t w;
    w.op = op;
    w.idx = idx;
    w.value = value;
    w.last = last;
    if (op == OP_ADD && gen_counting && !gen_written[idx]) begin
      for (int i = NUM_VARS - 1; i >= 0; i--) begin
        if (gen_written[i]) w.idx = i[2:0];
      end
    end
    if (op == OP_CLEAR) begin
      gen_counting = 1'b0;
    end else begin
      gen_written[w.idx] = 1'b1;
      if (last) gen_counting = 1'b1;
    end
    pending_words.push_back(w);
  endtask

  function automatic logic [31:0] random_value();
    logic [31:0] v;
    case ($urandom_range(7))
      0: begin
        case ($urandom_range(4))
          0: v = 32'h7FFF_FFFF;
          1: v = 32'h8000_0000;
          2: v = 32'h0000_0000;
          3: v = 32'hFFFF_FFFF;
          default: v = 32'h0001_0000;
        endcase
      end
      1, 2: v = $urandom();
      // Values clustered between -1.0 and 3.0 keep the variance in range.
      default: v = 32'($urandom_range(0, 32'h0003_FFFF)) - 32'h0001_0000;
    endcase
    return v;
  endfunction

  task automatic drain();
    while (pending_words.size() != 0 || expected_results.size() != 0) @(posedge clk);
  endtask

  // Sender: a word stays offered until it is taken.
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || word_taken) begin
      if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        s_tvalid <= 1'b1;
        s_tdata <= pending_words[0].value;
        s_tuser <= {pending_words[0].idx, pending_words[0].op};
        s_tlast <= pending_words[0].last;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver, with one long hold-off in the third phase that backs the block up.
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_taken) begin
      hold_taken <= hold_req;
      hold_left <= HOLD_CYCLES;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin : monitor
    stat_result_t got, want;
    if (rst) begin
      word_taken <= 1'b0;
    end else begin
      word_taken <= s_tvalid && s_tready;
      if (m_tvalid && m_tready) begin
        got.mean = m_tdata[31:0];
        got.variance = m_tdata[63:32];
        got.count = m_tdata[64 +: COUNT_W];
        if (expected_results.size() == 0) begin
          $error("result word with nothing expected: mean %h variance %h count %h",
                 got.mean, got.variance, got.count);
          mismatch_count++;
        end else begin
          want = expected_results.pop_front();
          if (got.mean !== want.mean) begin
            $error("mean_out: expected %h, got %h", want.mean, got.mean);
            mismatch_count++;
          end
          if (got.variance !== want.variance) begin
            $error("variance_out: expected %h, got %h", want.variance, got.variance);
            mismatch_count++;
          end
          if (got.count !== want.count) begin
            $error("sample_count: expected %h, got %h", want.count, got.count);
            mismatch_count++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        expected_results.push_back(welford_update(pending_words[0]));
        void'(pending_words.pop_front());
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("== FAIL ==");
    $finish;
  end

  initial begin : stimulus
    int produced, roll, nv;
    int send_pct[4];
    int recv_pct[4];
    send_pct = '{0, 63, 0, 38};
    recv_pct = '{0, 0, 63, 38};
    for (int i = 0; i < NUM_VARS; i++) begin
      run_mean[i] = 0;
      run_var[i] = 0;
      gen_written[i] = 1'b0;
    end
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int p = 0; p < 4; p++) begin
      send_idle_pct = send_pct[p];
      recv_stall_pct = recv_pct[p];
      if (p == 0) begin
        // Clear with its ignored fields at their extremes.
        queue_word(OP_CLEAR, 3'd7, 32'h7FFF_FFFF, 1'b1);
        // First sample after a clear overwrites every variable.
        queue_word(OP_ADD, 3'd0, 32'h7FFF_FFFF, 1'b0);
        queue_word(OP_ADD, 3'd1, 32'h8000_0000, 1'b0);
        queue_word(OP_ADD, 3'd2, 32'h0000_0000, 1'b0);
        queue_word(OP_ADD, 3'd3, 32'hFFFF_FFFF, 1'b0);
        queue_word(OP_ADD, 3'd4, 32'h0001_0000, 1'b0);
        queue_word(OP_ADD, 3'd5, 32'h0000_0001, 1'b0);
        queue_word(OP_ADD, 3'd6, 32'hFFFF_0000, 1'b0);
        queue_word(OP_ADD, 3'd7, 32'h1234_5678, 1'b1);
        // Opposite extremes drive the variance into saturation.
        queue_word(OP_ADD, 3'd0, 32'h8000_0000, 1'b0);
        queue_word(OP_ADD, 3'd1, 32'h7FFF_FFFF, 1'b0);
        queue_word(OP_ADD, 3'd2, 32'h0000_0000, 1'b0);
        queue_word(OP_ADD, 3'd3, 32'h0000_0001, 1'b0);
        queue_word(OP_ADD, 3'd4, 32'h0001_0000, 1'b0);
        queue_word(OP_ADD, 3'd5, 32'h8000_0000, 1'b0);
        queue_word(OP_ADD, 3'd6, 32'h7FFF_FFFF, 1'b0);
        queue_word(OP_ADD, 3'd7, 32'hEDCB_A987, 1'b1);
        queue_word(OP_ADD, 3'd2, 32'h7FFF_FFFF, 1'b1);
        queue_word(OP_ADD, 3'd5, 32'h0000_8000, 1'b0);
        queue_word(OP_CLEAR, 3'd0, 32'h8000_0000, 1'b0);
        queue_word(OP_ADD, 3'd3, 32'h0002_0000, 1'b1);
        queue_word(OP_ADD, 3'd3, 32'hFFFE_0000, 1'b1);
        queue_word(OP_CLEAR, 3'd4, 32'h0000_0000, 1'b1);
        queue_word(OP_CLEAR, 3'd1, 32'hFFFF_FFFF, 1'b0);
      end
      if (p == 2) hold_req++;
      // The count cannot reach its maximum within a run of this length.
      produced = 0;
      while (produced < PER_PHASE) begin
        roll = $urandom_range(99);
        if (roll < 4) begin
          queue_word(OP_CLEAR, 3'($urandom_range(7)), $urandom(), 1'($urandom_range(1)));
          produced++;
        end else if (roll < 12) begin
          queue_word(OP_ADD, 3'($urandom_range(7)), random_value(), 1'($urandom_range(1)));
          produced++;
        end else begin
          nv = ($urandom_range(3) == 0) ? $urandom_range(1, NUM_VARS) : NUM_VARS;
          for (int i = 0; i < nv; i++) begin
            queue_word(OP_ADD, i[2:0], random_value(), i == nv - 1);
          end
          produced += nv;
        end
      end
      drain();
    end

    repeat (END_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
